@@ rtl/sliding_window_mode_assert.svh @@
// Assertion macros for the sliding window mode block.
`ifndef SLIDING_WINDOW_MODE_ASSERT_SVH
`define SLIDING_WINDOW_MODE_ASSERT_SVH

// property must hold at every clock outside reset
`define SWM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sliding_window_mode: assertion failed");

// expression must never be true outside reset
`define SWM_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("sliding_window_mode: forbidden condition seen");

`endif

@@ rtl/swm_pkg.sv @@
// Types shared by the sliding window mode controller and datapath.
package swm_pkg;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CLEAR  = 8'b0000_0010,
        ST_RING   = 8'b0000_0100,
        ST_SSTART = 8'b0000_1000,
        ST_SCAN   = 8'b0001_0000,
        ST_WOLD   = 8'b0010_0000,
        ST_WNEW   = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } swm_state_t;

    typedef struct packed {
        logic load;
        logic clr_start;
        logic clr_step;
        logic ring_rd;
        logic scan_start;
        logic scan_step;
        logic wr_old;
        logic wr_new;
        logic out_load;
    } swm_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic emit;
        logic out_free;
    } swm_sts_t;

endpackage

@@ rtl/sliding_window_mode.sv @@
// Top level of the sliding window mode block: register port and unit wiring.
//   channel  | ports                              | role
//   s_       | s_valid s_ready s_sample s_restart | sample in
//   m_       | m_valid m_ready m_mode_value/count | window mode out
//   apb      | psel penable pwrite paddr pwdata   | window_len at 0x0
// Each item is handled by one read pass over the count table. A clearing pass over the
// table runs first after reset, after a window_len write and on restart. Items are taken
// one at a time; a finished result waits in the output register while the next item is
// accepted, and stalls only at its end.
module sliding_window_mode #(
    parameter int WINDOW_MAX = 256,
    parameter int VALUE_BITS = 32,
    localparam int LEN_W = $clog2(WINDOW_MAX + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_sample,
    input  logic                  s_restart,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_mode_value,
    output logic [LEN_W-1:0]      m_mode_count,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import swm_pkg::*;

    swm_cmd_t   cmd;
    swm_sts_t   sts;
    logic [8:0] window_len_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
    assign prdata = (paddr == 3'd0) ? {23'd0, window_len_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn)    window_len_reg <= 9'd1;
        else if (cfg_wr) window_len_reg <= pwdata[8:0];
    end

    swm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_restart (s_restart),
        .cfg_wr    (cfg_wr),
        .s_ready   (s_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    swm_dp #(
        .WINDOW_MAX (WINDOW_MAX),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_sample     (s_sample),
        .window_len   (window_len_reg),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_mode_value (m_mode_value),
        .m_mode_count (m_mode_count)
    );

endmodule

@@ rtl/swm_ctrl.sv @@
// Sequencer for the sliding window mode block.
module swm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_restart,
    input  logic               cfg_wr,
    output logic               s_ready,
    input  swm_pkg::swm_sts_t  sts,
    output swm_pkg::swm_cmd_t  cmd
);
    import swm_pkg::*;

    swm_state_t state_reg, state_next;
    logic       pend_reg, pend_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg | cfg_wr;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_restart || pend_reg) begin
                        cmd.clr_start = 1'b1;
                        pend_next     = 1'b0;
                        state_next    = ST_CLEAR;
                    end else begin
                        state_next = ST_RING;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) state_next = ST_RING;
            end
            ST_RING: begin
                cmd.ring_rd = 1'b1;
                state_next  = ST_SSTART;
            end
            ST_SSTART: begin
                cmd.scan_start = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) state_next = ST_WOLD;
            end
            ST_WOLD: begin
                cmd.wr_old = 1'b1;
                state_next = ST_WNEW;
            end
            ST_WNEW: begin
                cmd.wr_new = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!sts.emit) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b1;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

@@ rtl/swm_dp.sv @@
// Datapath: sample ring, value/count table, scan and output register.
module swm_dp #(
    parameter int WINDOW_MAX = 256,
    parameter int VALUE_BITS = 32,
    localparam int LEN_W = $clog2(WINDOW_MAX + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  swm_pkg::swm_cmd_t      cmd,
    output swm_pkg::swm_sts_t      sts,
    input  logic [VALUE_BITS-1:0]  s_sample,
    input  logic [8:0]             window_len,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic [VALUE_BITS-1:0]  m_mode_value,
    output logic [LEN_W-1:0]       m_mode_count
);
    import swm_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int AW    = IDX_W + 1;
    localparam int CW    = (LEN_W > 9) ? LEN_W : 9;

    logic [VALUE_BITS-1:0] ring_mem [WINDOW_MAX];
    logic [VALUE_BITS-1:0] val_mem  [WINDOW_MAX];
    logic [LEN_W-1:0]      cnt_mem  [WINDOW_MAX];

    logic [VALUE_BITS-1:0] ring_q, val_q, samp_reg, old_reg, best_val_reg;
    logic [LEN_W-1:0]      cnt_q, best_cnt_reg, old_cnt_reg, new_cnt_reg, fill_reg;
    logic [IDX_W-1:0]      ptr_reg, rd_idx_reg, idx_old_reg, idx_new_reg, idx_free_reg;
    logic [AW-1:0]         addr_reg;
    logic                  rd_vld_reg, rem_reg, m_valid_reg;
    logic                  fold_reg, fnew_reg, ffree_reg;

    logic [CW-1:0]         wl_ext;
    logic [LEN_W-1:0]      len;
    logic [IDX_W-1:0]      ptr_norm, ptr_adv, addr_idx, cnt_wa;
    logic [LEN_W-1:0]      cnt_wd;
    logic                  cnt_we, issue, mo, mn, nz, same;
    logic [LEN_W:0]        cp_w;
    logic [LEN_W-1:0]      cp;

    always_comb begin
        wl_ext = CW'(window_len);
        if (wl_ext == '0)                   len = LEN_W'(1);
        else if (wl_ext > CW'(WINDOW_MAX))  len = LEN_W'(WINDOW_MAX);
        else                                len = LEN_W'(wl_ext);
    end

    assign ptr_norm = (LEN_W'(ptr_reg) >= len) ? '0 : ptr_reg;
    assign ptr_adv  = (LEN_W'(ptr_reg) + LEN_W'(1) >= len) ? '0 : ptr_reg + IDX_W'(1);
    assign addr_idx = addr_reg[IDX_W-1:0];
    assign issue    = cmd.scan_step && (addr_reg < AW'(WINDOW_MAX));

    assign nz   = (cnt_q != '0);
    assign mo   = nz && rem_reg && (val_q == old_reg);
    assign mn   = nz && (val_q == samp_reg);
    assign cp_w = {1'b0, cnt_q} - {{LEN_W{1'b0}}, mo} + {{LEN_W{1'b0}}, mn};
    assign cp   = cp_w[LEN_W-1:0];
    assign same = fold_reg && (idx_old_reg == idx_new_reg);

    always_comb begin
        cnt_we = 1'b0;
        cnt_wa = addr_idx;
        cnt_wd = '0;
        if (cmd.clr_step) begin
            cnt_we = 1'b1;
        end else if (cmd.wr_old) begin
            cnt_we = fold_reg;
            cnt_wa = idx_old_reg;
            cnt_wd = old_cnt_reg - LEN_W'(1);
        end else if (cmd.wr_new) begin
            cnt_we = 1'b1;
            if (fnew_reg) begin
                cnt_wa = idx_new_reg;
                cnt_wd = same ? new_cnt_reg : new_cnt_reg + LEN_W'(1);
            end else begin
                cnt_wa = ffree_reg ? idx_free_reg : idx_old_reg;
                cnt_wd = LEN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ring_rd)    ring_q <= ring_mem[ptr_norm];
        if (cmd.scan_start) ring_mem[ptr_reg] <= samp_reg;
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
        if (issue)  cnt_q <= cnt_mem[addr_idx];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_new && !fnew_reg) val_mem[cnt_wa] <= samp_reg;
        if (issue) val_q <= val_mem[addr_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            ptr_reg     <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_vld_reg <= issue;
            if (cmd.clr_start) begin
                addr_reg <= '0;
                ptr_reg  <= '0;
                fill_reg <= '0;
            end
            if (cmd.clr_step || issue) addr_reg <= addr_reg + AW'(1);
            if (cmd.ring_rd) ptr_reg <= ptr_norm;
            if (cmd.scan_start) begin
                addr_reg <= '0;
                ptr_reg  <= ptr_adv;
                if (fill_reg < len) fill_reg <= fill_reg + LEN_W'(1);
            end
            if (cmd.out_load)            m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load)    samp_reg <= s_sample;
        if (cmd.ring_rd) rem_reg  <= (fill_reg >= len);
        if (cmd.scan_start) begin
            old_reg      <= ring_q;
            fold_reg     <= 1'b0;
            fnew_reg     <= 1'b0;
            ffree_reg    <= 1'b0;
            best_cnt_reg <= '0;
            best_val_reg <= '0;
        end
        if (rd_vld_reg) begin
            if (mo) begin
                fold_reg    <= 1'b1;
                idx_old_reg <= rd_idx_reg;
                old_cnt_reg <= cnt_q;
            end
            if (mn) begin
                fnew_reg    <= 1'b1;
                idx_new_reg <= rd_idx_reg;
                new_cnt_reg <= cnt_q;
            end
            if (!nz && !ffree_reg) begin
                ffree_reg    <= 1'b1;
                idx_free_reg <= rd_idx_reg;
            end
            if (cp != '0 && (cp > best_cnt_reg ||
                             (cp == best_cnt_reg && val_q < best_val_reg))) begin
                best_cnt_reg <= cp;
                best_val_reg <= val_q;
            end
        end
        if (issue) rd_idx_reg <= addr_idx;
        // new value not yet in the table counts once
        if (cmd.wr_new && !fnew_reg &&
            (best_cnt_reg == '0 ||
             (best_cnt_reg == LEN_W'(1) && samp_reg < best_val_reg))) begin
            best_cnt_reg <= LEN_W'(1);
            best_val_reg <= samp_reg;
        end
        if (cmd.out_load) begin
            m_mode_value <= best_val_reg;
            m_mode_count <= best_cnt_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign sts.clr_last  = (addr_reg == AW'(WINDOW_MAX - 1));
    assign sts.scan_done = !rd_vld_reg && (addr_reg == AW'(WINDOW_MAX));
    assign sts.emit      = (fill_reg >= len);
    assign sts.out_free  = !m_valid_reg || m_ready;

endmodule

@@ rtl/swm_chk.sv @@
// Port-level checker for the sliding window mode block, with its bind.
`include "sliding_window_mode_assert.svh"

module swm_chk #(
    parameter int WINDOW_MAX = 256,
    parameter int VALUE_BITS = 32,
    localparam int LEN_W = $clog2(WINDOW_MAX + 1)
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [VALUE_BITS-1:0] m_mode_value,
    input logic [LEN_W-1:0]      m_mode_count
);
    `SWM_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_mode_value) && $stable(m_mode_count))
    `SWM_NEVER(a_cnt_nz, aclk, aresetn, m_valid && m_mode_count == '0)
    `SWM_ASSERT(a_one_item, aclk, aresetn, s_valid && s_ready |=> !s_ready)
endmodule

bind sliding_window_mode swm_chk #(
    .WINDOW_MAX (WINDOW_MAX),
    .VALUE_BITS (VALUE_BITS)
) u_swm_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_mode_value (m_mode_value),
    .m_mode_count (m_mode_count)
);

@@ verif/tb_sliding_window_mode.sv @@
// Testbench for sliding_window_mode: directed table plus random phases, checked by a window-mode predictor.
module tb_sliding_window_mode;
    import swm_pkg::*;

    localparam int WMAX = 256;
    localparam int LEN_W = 9;
    localparam logic [2:0] ADDR_WINDOW_LEN = 3'd0;
    localparam int SETTLE = 2 * WMAX + 40;
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct {
        logic [31:0] value;
        logic [LEN_W-1:0] count;
    } mode_t;

    typedef struct {
        int unsigned wl;       // nonzero: write window_len = wl - 1 first
        logic [31:0] sample;
        bit restart;
        bit typed;
        logic [31:0] ev;
        logic [LEN_W-1:0] ec;
    } row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0, s_restart = 0, m_ready = 0;
    logic [31:0] s_sample = 0;
    logic s_ready, m_valid, pready;
    logic [31:0] m_mode_value, prdata;
    logic [LEN_W-1:0] m_mode_count;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = 0;
    logic [31:0] pwdata = 0;

    sliding_window_mode dut (.*);

    mode_t expected_modes[$];
    logic [31:0] window_samples[$];
    logic [LEN_W-1:0] window_len_reg = 1;
    int errors = 0;
    int cycles = 0;
    bit calm = 0;
    logic [31:0] pool[4];

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, compare on every accepted item
    always @(posedge aclk) begin
        mode_t e;
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
        if (aresetn && m_valid && m_ready) begin
            if (expected_modes.size() == 0) begin
                $error("unexpected item: mode_value=%h mode_count=%0d",
                       m_mode_value, m_mode_count);
                errors++;
            end else begin
                e = expected_modes.pop_front();
                if (m_mode_value !== e.value) begin
                    $error("mode_value expected %h actual %h", e.value, m_mode_value);
                    errors++;
                end
                if (m_mode_count !== e.count) begin
                    $error("mode_count expected %0d actual %0d", e.count, m_mode_count);
                    errors++;
                end
            end
        end
    end

    function automatic int unsigned active_len();
        if (window_len_reg == 0) return 1;
        if (window_len_reg > WMAX) return WMAX;
        return window_len_reg;
    endfunction

    // returns 1 and the mode when the window is full
    function automatic bit window_mode(input logic [31:0] smp, input bit rst, output mode_t m);
        int unsigned n;
        int unsigned c;
        if (rst) window_samples.delete();
        window_samples.push_back(smp);
        if (window_samples.size() > active_len()) void'(window_samples.pop_front());
        if (window_samples.size() < active_len()) return 0;
        m.count = 0;
        m.value = 0;
        foreach (window_samples[i]) begin
            n = 0;
            foreach (window_samples[j]) if (window_samples[j] == window_samples[i]) n++;
            c = n;
            if (c > m.count || (c == m.count && window_samples[i] < m.value)) begin
                m.count = LEN_W'(c);
                m.value = window_samples[i];
            end
        end
        return 1;
    endfunction

    task automatic write_window_len(input logic [31:0] v);
        s_valid <= 0;
        wait (expected_modes.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= ADDR_WINDOW_LEN; pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        window_len_reg = v[LEN_W-1:0];
        window_samples.delete();
    endtask

    task automatic send_sample(input logic [31:0] smp, input bit rst, input bit typed,
                               input mode_t tm);
        mode_t m;
        if (!calm) begin
            while ($urandom_range(99) < 37) begin
                s_valid <= 0;
                @(posedge aclk);
            end
        end
        s_valid <= 1; s_sample <= smp; s_restart <= rst;
        do @(posedge aclk); while (!s_ready);
        if (window_mode(smp, rst, m)) expected_modes.push_back(typed ? tm : m);
    endtask

    function automatic logic [31:0] pick_sample();
        int unsigned r = $urandom_range(99);
        if (r < 80) return pool[$urandom_range(3)];
        if (r < 85) return 32'h0;
        if (r < 90) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    row_t directed[] = '{
        '{0, 32'h0000_0000, 0, 1, 32'h0000_0000, 9'd1},
        '{0, 32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFFF, 9'd1},
        '{0, 32'h8000_0001, 1, 1, 32'h8000_0001, 9'd1},
        '{4, 32'h5,         0, 0, 0, 0},
        '{0, 32'h5,         0, 0, 0, 0},
        '{0, 32'h7,         0, 0, 0, 0},
        '{0, 32'h7,         0, 0, 0, 0},
        '{0, 32'h9,         0, 0, 0, 0},
        '{0, 32'h3,         0, 0, 0, 0},
        '{0, 32'h7,         1, 0, 0, 0},
        '{0, 32'hFFFF_FFFF, 0, 0, 0, 0},
        '{0, 32'h0,         0, 0, 0, 0},
        '{0, 32'h0,         0, 0, 0, 0},
        '{1, 32'h1234_5678, 0, 1, 32'h1234_5678, 9'd1},
        '{1, 32'hA5A5_A5A5, 0, 1, 32'hA5A5_A5A5, 9'd1},
        '{3, 32'h2,         0, 0, 0, 0},
        '{0, 32'h1,         0, 0, 0, 0},
        '{0, 32'h1,         0, 0, 0, 0},
        '{0, 32'h2,         0, 0, 0, 0}
    };

    int unsigned phase_len[] = '{2, 3, 7, 16, 256, 5, 512, 2, 0, 256};
    int unsigned phase_items[] = '{50, 50, 50, 60, 300, 40, 20, 30, 20, 10};

    initial begin
        mode_t tm;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        foreach (directed[i]) begin
            if (directed[i].wl != 0) write_window_len(directed[i].wl - 1);
            tm.value = directed[i].ev;
            tm.count = directed[i].ec;
            send_sample(directed[i].sample, directed[i].restart, directed[i].typed, tm);
        end
        foreach (phase_len[p]) begin
            // window_len 512 wraps to 0 in 9 bits; 511 covers saturation
            write_window_len(phase_len[p] == 512 ? 32'h1FF : phase_len[p]);
            foreach (pool[k]) pool[k] = $urandom;
            for (int n = 0; n < phase_items[p]; n++) begin
                calm = (p == 4 && n >= 100 && n < 200);
                send_sample(pick_sample(), $urandom_range(99) < 3, 0, tm);
            end
            calm = 0;
        end
        s_valid <= 0;
        wait (expected_modes.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
